// ----- rtl/ptt_pkg.sv -----
`timescale 1ns / 1ps

package ptt_pkg;

	// Field widths of one task entry.
	localparam int HANDLE_W = 16;
	localparam int TIME_W   = 32;

	// A dispatch reports at most this many tasks; the counter holds the limit itself.
	localparam int MAX_RESULTS = 8;
	localparam int RUN_CNT_W   = 4;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_ADD      = 2'd1,
		OP_DELETE   = 2'd2,
		OP_DISPATCH = 2'd3
	} op_t;

	// Result status codes.
	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_FULL  = 3'd1;
	localparam logic [2:0] ST_FREED = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_NONE  = 3'd5;

	// One word of the slot memory.
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   delay;
		logic [TIME_W-1:0]   period;
	} entry_t;

	// Event from the slot engine to the result stage.
	// run: a pending task was found; close: the current item is complete.
	typedef struct packed {
		logic                run;
		logic                close;
		logic [2:0]          status;
		logic [2:0]          slot;
		logic [HANDLE_W-1:0] handle;
	} evt_t;

endpackage

// ----- rtl/periodic_task_timer_table_top.sv -----
`timescale 1ns / 1ps
// Add and delete: the single result beat appears in the cycle after the accepting edge; busy stays
// low, so one of these may be accepted every cycle.
// Tick and dispatch: busy while the slot memory is walked one slot per cycle, then through the last
// and closing states; the last result beat is registered from the closing state.
// Reset clears the per-slot busy and pending flags; the slot memory is not cleared, since an
// entry is only used while its slot is busy. The receiver cannot stall result beats.

module periodic_task_timer_table_top #(
	parameter int TASK_SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [ptt_pkg::HANDLE_W-1:0] task_handle,
	input  logic [ptt_pkg::TIME_W-1:0]   first_delay,
	input  logic [ptt_pkg::TIME_W-1:0]   repeat_period,
	input  logic [2:0]                   slot_index,
	output logic                         valid,
	output logic [2:0]                   status,
	output logic [2:0]                   slot_out,
	output logic [ptt_pkg::HANDLE_W-1:0] handle_out,
	output logic                         last
);

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	logic            ram_we;
	logic [SW-1:0]   ram_waddr;
	logic [SW-1:0]   ram_raddr;
	ptt_pkg::entry_t ram_wdata;
	ptt_pkg::entry_t ram_rdata;
	ptt_pkg::evt_t   evt;

	// Slot memory: handle, countdown and period of every slot.
	ptt_ram #(
		.WIDTH($bits(ptt_pkg::entry_t)),
		.DEPTH(TASK_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Command decode, slot flags and the memory walk.
	ptt_engine #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.task_handle  (task_handle),
		.first_delay  (first_delay),
		.repeat_period(repeat_period),
		.slot_index   (slot_index),
		.busy         (busy),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.evt          (evt)
	);

	// Result beats with the final-beat mark.
	ptt_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.valid     (valid),
		.status    (status),
		.slot_out  (slot_out),
		.handle_out(handle_out),
		.last      (last)
	);

endmodule

// ----- rtl/ptt_ram.sv -----
`timescale 1ns / 1ps

module ptt_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/ptt_engine.sv -----
`timescale 1ns / 1ps

module ptt_engine #(
	parameter int TASK_SLOTS = 8,
	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
	localparam int IW = (SW > 3) ? SW : 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    op,
	input  logic [ptt_pkg::HANDLE_W-1:0]  task_handle,
	input  logic [ptt_pkg::TIME_W-1:0]    first_delay,
	input  logic [ptt_pkg::TIME_W-1:0]    repeat_period,
	input  logic [2:0]                    slot_index,
	output logic                          busy,
	output logic                          ram_we,
	output logic [SW-1:0]                 ram_waddr,
	output ptt_pkg::entry_t               ram_wdata,
	output logic [SW-1:0]                 ram_raddr,
	input  ptt_pkg::entry_t               ram_rdata,
	output ptt_pkg::evt_t                 evt
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_LAST  = 4'b0100,
		S_CLOSE = 4'b1000
	} state_t;

	state_t                       state_q;
	ptt_pkg::op_t                 op_q;
	ptt_pkg::op_t                 op_in;
	logic [SW-1:0]                cnt_q;
	logic                         valid_s1;
	logic [SW-1:0]                slot_s1;
	logic [ptt_pkg::RUN_CNT_W-1:0] runs_q;
	logic [TASK_SLOTS-1:0]        busy_q;
	logic [TASK_SLOTS-1:0]        pending_q;

	logic          accept;
	logic          free_found;
	logic [SW-1:0] free_idx;
	logic [IW-1:0] del_idx;
	logic [SW-1:0] del_slot;
	logic          del_ok;
	logic          add_wr;
	logic          slot_live;
	logic          due;
	logic          tick_wr;
	logic          run_hit;

	assign op_in  = ptt_pkg::op_t'(op);
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Lowest free slot for an add.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// Delete target and its range check.
	assign del_idx  = IW'(slot_index);
	assign del_slot = del_idx[SW-1:0];
	assign del_ok   = ({29'd0, slot_index} < 32'(TASK_SLOTS));

	assign add_wr = accept && (op_in == ptt_pkg::OP_ADD) && free_found;

	// Second walk stage: the entry read for slot_s1 is on the memory output.
	assign slot_live = busy_q[slot_s1];
	assign due       = (ram_rdata.delay == '0);
	assign tick_wr   = valid_s1 && (op_q == ptt_pkg::OP_TICK) && slot_live;
	assign run_hit   = valid_s1 && (op_q == ptt_pkg::OP_DISPATCH) && slot_live &&
		pending_q[slot_s1] && (runs_q < ptt_pkg::RUN_CNT_W'(ptt_pkg::MAX_RESULTS));

	// Memory access: adds write the new entry, ticks write back the updated countdown.
	// A due slot reloads from its period, which also leaves a one-shot at zero.
	always_comb begin
		ram_raddr = cnt_q;
		ram_we    = add_wr || tick_wr;
		if (add_wr) begin
			ram_waddr        = free_idx;
			ram_wdata.handle = task_handle;
			ram_wdata.delay  = first_delay;
			ram_wdata.period = repeat_period;
		end else begin
			ram_waddr        = slot_s1;
			ram_wdata.handle = ram_rdata.handle;
			ram_wdata.delay  = due ? ram_rdata.period : ram_rdata.delay - 1'b1;
			ram_wdata.period = ram_rdata.period;
		end
	end

	// Events toward the result stage.
	always_comb begin
		evt = '0;
		if (run_hit) begin
			evt.run    = 1'b1;
			evt.status = ptt_pkg::ST_RUN;
			evt.slot   = 3'(slot_s1);
			evt.handle = ram_rdata.handle;
		end
		if (accept && (op_in == ptt_pkg::OP_ADD)) begin
			evt.close  = 1'b1;
			evt.status = free_found ? ptt_pkg::ST_ADDED : ptt_pkg::ST_FULL;
			evt.slot   = free_found ? 3'(free_idx) : 3'd0;
		end
		if (accept && (op_in == ptt_pkg::OP_DELETE)) begin
			evt.close  = 1'b1;
			evt.status = (del_ok && busy_q[del_slot]) ? ptt_pkg::ST_FREED : ptt_pkg::ST_EMPTY;
			evt.slot   = slot_index;
		end
		if (state_q == S_CLOSE) begin
			evt.close  = 1'b1;
			evt.status = ptt_pkg::ST_NONE;
		end
	end

	// Busy and pending flags for every slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			pending_q <= '0;
		end else begin
			if (add_wr) begin
				busy_q[free_idx]    <= 1'b1;
				pending_q[free_idx] <= 1'b0;
			end
			if (accept && (op_in == ptt_pkg::OP_DELETE) && del_ok) begin
				busy_q[del_slot]    <= 1'b0;
				pending_q[del_slot] <= 1'b0;
			end
			if (tick_wr && due) begin
				pending_q[slot_s1] <= 1'b1;
			end
			if (run_hit) begin
				pending_q[slot_s1] <= 1'b0;
				if (ram_rdata.period == '0) begin
					busy_q[slot_s1] <= 1'b0;
				end
			end
		end
	end

	// Walk sequencer: one memory read per slot, then a closing beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= ptt_pkg::OP_TICK;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			slot_s1  <= '0;
			runs_q   <= '0;
		end else begin
			valid_s1 <= (state_q == S_WALK);
			slot_s1  <= cnt_q;
			if (run_hit) begin
				runs_q <= runs_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && ((op_in == ptt_pkg::OP_TICK) ||
						(op_in == ptt_pkg::OP_DISPATCH))) begin
						state_q <= S_WALK;
						op_q    <= op_in;
						cnt_q   <= '0;
						runs_q  <= '0;
					end
				end
				S_WALK: begin
					if (cnt_q == SW'(TASK_SLOTS - 1)) begin
						state_q <= S_LAST;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LAST: begin
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/ptt_result.sv -----
`timescale 1ns / 1ps

module ptt_result (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptt_pkg::evt_t                evt,
	output logic                         valid,
	output logic [2:0]                   status,
	output logic [2:0]                   slot_out,
	output logic [ptt_pkg::HANDLE_W-1:0] handle_out,
	output logic                         last
);

	logic                         held_v_q;
	logic [2:0]                   held_slot_q;
	logic [ptt_pkg::HANDLE_W-1:0] held_handle_q;
	logic                         valid_q;

	assign valid = valid_q;

	// Control: a run beat is held back until the next one or the close shows
	// whether it is the final beat of its dispatch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			valid_q <= evt.run ? held_v_q : evt.close;
			if (evt.run) begin
				held_v_q <= 1'b1;
			end else if (evt.close) begin
				held_v_q <= 1'b0;
			end
		end
	end

	// Payload of the held beat and of the output beat.
	always_ff @(posedge clk) begin
		if (evt.run) begin
			held_slot_q   <= evt.slot;
			held_handle_q <= evt.handle;
			status        <= ptt_pkg::ST_RUN;
			slot_out      <= held_slot_q;
			handle_out    <= held_handle_q;
			last          <= 1'b0;
		end else if (evt.close) begin
			last <= 1'b1;
			if (held_v_q) begin
				status     <= ptt_pkg::ST_RUN;
				slot_out   <= held_slot_q;
				handle_out <= held_handle_q;
			end else begin
				status     <= evt.status;
				slot_out   <= evt.slot;
				handle_out <= evt.handle;
			end
		end
	end

endmodule
